>>> rtl/core/sem_pkg.sv
// Shared types, constants and helper functions for the Sobel edge marker.
// Used by sem_front, sem_back and the top level; depends on nothing.
package sem_pkg;

  localparam int PIX_W          = 8;
  localparam int GRAD_W         = 11;  // signed Sobel sum, |g| <= 4*255
  localparam int MAG_INT_W      = 11;  // integer bits of sqrt(gx^2+gy^2)
  localparam int DIM_IN_W       = 9;
  localparam int DEF_MAX_ROWS   = 256;
  localparam int DEF_MAX_COLS   = 256;
  localparam int DEF_FRAC_BITS  = 4;
  localparam int TAP_W          = 4;
  localparam int NUM_TAPS       = 9;

  localparam logic [PIX_W-1:0] EDGE_VALUE       = 8'd0;
  localparam logic [PIX_W-1:0] BACKGROUND_VALUE = 8'd255;

  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_FETCH = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [PIX_W-1:0] pixel;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TAP,
    ST_SQ,
    ST_ROOT_GO,
    ST_ROOT,
    ST_WRITE,
    ST_FRD,
    ST_FCMP
  } back_st_t;

  // Neighbor row (0 above, 1 same, 2 below) of a tap in raster order.
  function automatic logic [1:0] tap_row(input logic [TAP_W-1:0] t);
    logic [1:0] r;
    case (t)
      4'd0, 4'd1, 4'd2: r = 2'd0;
      4'd3, 4'd4, 4'd5: r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] tap_col(input logic [TAP_W-1:0] t);
    logic [1:0] c;
    case (t)
      4'd0, 4'd3, 4'd6: c = 2'd0;
      4'd1, 4'd4, 4'd7: c = 2'd1;
      default:          c = 2'd2;
    endcase
    return c;
  endfunction

  // Contribution of one pixel to gx: mask {{-1,0,1},{-2,0,2},{-1,0,1}}.
  function automatic logic signed [GRAD_W-1:0] term_x(input logic [TAP_W-1:0] t,
                                                     input logic [PIX_W-1:0] p);
    logic signed [GRAD_W-1:0] v;
    v = $signed({{(GRAD_W-PIX_W){1'b0}}, p});
    case (t)
      4'd0, 4'd6: term_x = -v;
      4'd3:       term_x = -(v <<< 1);
      4'd2, 4'd8: term_x = v;
      4'd5:       term_x = v <<< 1;
      default:    term_x = '0;
    endcase
  endfunction

  // Contribution of one pixel to gy: mask {{-1,-2,-1},{0,0,0},{1,2,1}}.
  function automatic logic signed [GRAD_W-1:0] term_y(input logic [TAP_W-1:0] t,
                                                     input logic [PIX_W-1:0] p);
    logic signed [GRAD_W-1:0] v;
    v = $signed({{(GRAD_W-PIX_W){1'b0}}, p});
    case (t)
      4'd0, 4'd2: term_y = -v;
      4'd1:       term_y = -(v <<< 1);
      4'd6, 4'd8: term_y = v;
      4'd7:       term_y = v <<< 1;
      default:    term_y = '0;
    endcase
  endfunction

endpackage

>>> rtl/core/sem_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module sem_ram #(
  parameter int W = 8,
  parameter int D = 256
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/sem_isqrt.sv
// Iterative integer square root, one result bit per cycle.
// No package dependencies.
module sem_isqrt #(
  parameter int MAG_W = 15
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [2*MAG_W-1:0] radicand,
  output logic               done,
  output logic [MAG_W-1:0]   root
);

  localparam int RAD_W = 2 * MAG_W;
  localparam int REM_W = MAG_W + 2;
  localparam int CUR_W = MAG_W + 4;
  localparam int CNT_W = $clog2(MAG_W + 1);

  logic [RAD_W-1:0] rad;
  logic [REM_W-1:0] remv;
  logic [CNT_W-1:0] cnt;
  logic             running;
  logic [CUR_W-1:0] cur;
  logic [CUR_W-1:0] trial;
  logic             fits;

  assign cur   = {remv, rad[RAD_W-1 -: 2]};
  assign trial = {2'b00, root, 2'b01};
  assign fits  = cur >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CNT_W'(MAG_W);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      remv <= '0;
      root <= '0;
    end else if (running) begin
      rad <= rad << 2;
      if (fits) begin
        remv <= REM_W'(cur - trial);
        root <= {root[MAG_W-2:0], 1'b1};
      end else begin
        remv <= REM_W'(cur);
        root <= {root[MAG_W-2:0], 1'b0};
      end
    end
  end

endmodule

>>> rtl/core/sem_front.sv
// Front end: takes command items and holds them in a two-entry queue.
// Depends on sem_pkg.
module sem_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  sem_pkg::item_t        push_item,
  output logic                  full,
  output logic                  head_valid,
  output sem_pkg::item_t        head_item,
  input  logic                  pop
);

  sem_pkg::item_t slot [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign full       = count == 2'd2;
  assign head_valid = count != 2'd0;
  assign head_item  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_item;
    end
  end

endmodule

>>> rtl/core/sem_back.sv
// Back end: pixel store, Sobel compute pass, magnitude store and fetch path.
// Depends on sem_pkg, sem_ram and sem_isqrt.
module sem_back #(
  parameter int MAX_ROWS  = sem_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS  = sem_pkg::DEF_MAX_COLS,
  parameter int FRAC_BITS = sem_pkg::DEF_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  input  sem_pkg::item_t                item,
  output logic                          item_pop,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [sem_pkg::DIM_IN_W-1:0]  cfg_data,
  output logic                          out_valid,
  output logic [sem_pkg::PIX_W-1:0]     pixel_out,
  output logic                          last
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int TW    = AW + 1;
  localparam int RW    = $clog2(MAX_ROWS + 1);
  localparam int CW    = $clog2(MAX_COLS + 1);
  localparam int MAG_W = sem_pkg::MAG_INT_W + FRAC_BITS;
  localparam int SQ_W  = 2 * sem_pkg::GRAD_W - 1;
  localparam int SUM_W = MAG_W + AW;
  localparam int PRD_W = MAG_W + TW;
  localparam int GW    = sem_pkg::GRAD_W;

  sem_pkg::back_st_t state, state_next;

  logic [RW-1:0]    rows;
  logic [CW-1:0]    cols;
  logic [TW-1:0]    total;
  logic [TW-1:0]    load_address;
  logic [TW-1:0]    fetch_address;
  logic [SUM_W-1:0] magnitude_sum;
  logic             result_ready;

  logic [AW-1:0]    base_u, base_c, base_d;
  logic [RW-1:0]    row_d;
  logic [CW-1:0]    col;
  logic [AW-1:0]    pix_addr;
  logic [sem_pkg::TAP_W-1:0] tap;
  logic signed [GW-1:0] gx, gy;
  logic [SQ_W-1:0]  sq;
  logic [PRD_W-1:0] prod;

  logic [CW-1:0]    col_l, col_r, tap_c;
  logic [AW-1:0]    tap_base;
  logic [sem_pkg::TAP_W-1:0] tap_prev;
  logic [TW-1:0]    load_at;
  logic             load_done;
  logic             last_col, last_pix;
  logic signed [2*GW-1:0] gx_w, gy_w;
  logic [2*GW-1:0]  sq_full;

  logic             pix_we, pix_re;
  logic [AW-1:0]    pix_raddr;
  logic [sem_pkg::PIX_W-1:0] pix_rdata;
  logic             mag_we, mag_re;
  logic [MAG_W-1:0] mag_rdata;
  logic             root_start, root_done;
  logic [MAG_W-1:0] root;

  function automatic logic [RW-1:0] clamp_rows(input logic [sem_pkg::DIM_IN_W-1:0] v);
    if (v == '0) return RW'(1);
    if (32'(v) > MAX_ROWS) return RW'(MAX_ROWS);
    return RW'(v);
  endfunction

  function automatic logic [CW-1:0] clamp_cols(input logic [sem_pkg::DIM_IN_W-1:0] v);
    if (v == '0) return CW'(1);
    if (32'(v) > MAX_COLS) return CW'(MAX_COLS);
    return CW'(v);
  endfunction

  // Neighbor address for the current tap, with wrap at the borders.
  assign col_l    = (col == '0) ? cols - 1'b1 : col - 1'b1;
  assign col_r    = (col + 1'b1 == cols) ? '0 : col + 1'b1;
  assign tap_prev = tap - 1'b1;

  always_comb begin
    case (sem_pkg::tap_row(tap))
      2'd0:    tap_base = base_u;
      2'd1:    tap_base = base_c;
      default: tap_base = base_d;
    endcase
    case (sem_pkg::tap_col(tap))
      2'd0:    tap_c = col_l;
      2'd1:    tap_c = col;
      default: tap_c = col_r;
    endcase
  end

  assign pix_raddr = AW'(tap_base + AW'(tap_c));
  assign pix_re    = (state == sem_pkg::ST_TAP) && (tap < sem_pkg::TAP_W'(sem_pkg::NUM_TAPS));

  assign load_at   = result_ready ? '0 : load_address;
  assign load_done = (load_at + 1'b1) >= total;
  assign last_col  = (col + 1'b1) == cols;
  assign last_pix  = (TW'(pix_addr) + 1'b1) == total;
  assign gx_w      = (2*GW)'(gx);
  assign gy_w      = (2*GW)'(gy);
  assign sq_full   = $unsigned(gx_w * gx_w) + $unsigned(gy_w * gy_w);

  assign item_pop   = item_valid && (state == sem_pkg::ST_IDLE) && !cfg_we;
  assign pix_we     = item_pop && (item.kind == sem_pkg::KIND_LOAD);
  assign mag_re     = item_pop && (item.kind == sem_pkg::KIND_FETCH) && result_ready;
  assign mag_we     = (state == sem_pkg::ST_WRITE);
  assign root_start = (state == sem_pkg::ST_ROOT_GO);

  always_comb begin
    state_next = state;
    case (state)
      sem_pkg::ST_IDLE: begin
        if (pix_we && load_done) begin
          state_next = sem_pkg::ST_TAP;
        end else if (mag_re) begin
          state_next = sem_pkg::ST_FRD;
        end
      end
      sem_pkg::ST_TAP: begin
        if (tap == sem_pkg::TAP_W'(sem_pkg::NUM_TAPS)) begin
          state_next = sem_pkg::ST_SQ;
        end
      end
      sem_pkg::ST_SQ:      state_next = sem_pkg::ST_ROOT_GO;
      sem_pkg::ST_ROOT_GO: state_next = sem_pkg::ST_ROOT;
      sem_pkg::ST_ROOT: begin
        if (root_done) begin
          state_next = sem_pkg::ST_WRITE;
        end
      end
      sem_pkg::ST_WRITE:   state_next = last_pix ? sem_pkg::ST_IDLE : sem_pkg::ST_TAP;
      sem_pkg::ST_FRD:     state_next = sem_pkg::ST_FCMP;
      sem_pkg::ST_FCMP:    state_next = sem_pkg::ST_IDLE;
      default:             state_next = sem_pkg::ST_IDLE;
    endcase
    if (cfg_we) begin
      state_next = sem_pkg::ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= sem_pkg::ST_IDLE;
      rows          <= clamp_rows(9'd256);
      cols          <= clamp_cols(9'd256);
      load_address  <= '0;
      fetch_address <= '0;
      magnitude_sum <= '0;
      result_ready  <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == sem_pkg::CFG_ROWS) begin
          rows <= clamp_rows(cfg_data);
        end else begin
          cols <= clamp_cols(cfg_data);
        end
        load_address  <= '0;
        fetch_address <= '0;
        magnitude_sum <= '0;
        result_ready  <= 1'b0;
      end else begin
        if (pix_we) begin
          result_ready  <= 1'b0;
          load_address  <= load_done ? '0 : load_at + 1'b1;
          fetch_address <= '0;
          if (load_done) begin
            magnitude_sum <= '0;
          end
        end
        if (mag_we) begin
          magnitude_sum <= magnitude_sum + SUM_W'(root);
          if (last_pix) begin
            result_ready <= 1'b1;
          end
        end
        if (state == sem_pkg::ST_FCMP) begin
          out_valid <= 1'b1;
          if ((fetch_address + 1'b1) >= total) begin
            fetch_address <= '0;
            result_ready  <= 1'b0;
          end else begin
            fetch_address <= fetch_address + 1'b1;
          end
        end
      end
    end
  end

  // Datapath registers, no reset needed.
  always_ff @(posedge clk) begin
    total <= TW'(rows * cols);
    if (pix_we && load_done) begin
      col      <= '0;
      pix_addr <= '0;
      base_c   <= '0;
      base_u   <= AW'(total - TW'(cols));
      base_d   <= (rows == RW'(1)) ? '0 : AW'(cols);
      row_d    <= (rows == RW'(1)) ? '0 : RW'(1);
      tap      <= '0;
      gx       <= '0;
      gy       <= '0;
    end
    if (state == sem_pkg::ST_TAP) begin
      tap <= tap + 1'b1;
      if (tap != '0) begin
        gx <= gx + sem_pkg::term_x(tap_prev, pix_rdata);
        gy <= gy + sem_pkg::term_y(tap_prev, pix_rdata);
      end
    end
    if (state == sem_pkg::ST_SQ) begin
      sq <= SQ_W'(sq_full);
    end
    if (mag_we) begin
      tap      <= '0;
      gx       <= '0;
      gy       <= '0;
      pix_addr <= pix_addr + 1'b1;
      if (last_col) begin
        col    <= '0;
        base_u <= base_c;
        base_c <= base_d;
        if (row_d + 1'b1 == rows) begin
          row_d  <= '0;
          base_d <= '0;
        end else begin
          row_d  <= row_d + 1'b1;
          base_d <= base_d + AW'(cols);
        end
      end else begin
        col <= col + 1'b1;
      end
    end
    if (state == sem_pkg::ST_FRD) begin
      prod <= PRD_W'(mag_rdata) * PRD_W'(total);
    end
    if (state == sem_pkg::ST_FCMP) begin
      pixel_out <= (PRD_W'(prod) >= PRD_W'(magnitude_sum)) ?
                   sem_pkg::EDGE_VALUE : sem_pkg::BACKGROUND_VALUE;
      last      <= (fetch_address + 1'b1) >= total;
    end
  end

  sem_ram #(.W(sem_pkg::PIX_W), .D(DEPTH)) u_pixel_store (
    .clk   (clk),
    .we    (pix_we),
    .waddr (load_at[AW-1:0]),
    .wdata (item.pixel),
    .re    (pix_re),
    .raddr (pix_raddr),
    .rdata (pix_rdata)
  );

  sem_ram #(.W(MAG_W), .D(DEPTH)) u_magnitude_store (
    .clk   (clk),
    .we    (mag_we),
    .waddr (pix_addr),
    .wdata (root),
    .re    (mag_re),
    .raddr (fetch_address[AW-1:0]),
    .rdata (mag_rdata)
  );

  sem_isqrt #(.MAG_W(MAG_W)) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (root_start),
    .radicand ((2*MAG_W)'(sq) << (2 * FRAC_BITS)),
    .done     (root_done),
    .root     (root)
  );

endmodule

>>> rtl/core/sobel_edge_mean_threshold.sv
// Top level of the Sobel edge marker with mean threshold.
// Depends on sem_pkg, sem_front and sem_back (which holds the RAMs and sqrt unit).
//
// Load a rows x cols grey frame in raster order (kind=0, one pixel per item),
// then fetch marks (kind=1): 0 for edge, 255 for background, last=1 on the
// final pixel. An item is taken when start is high and busy is low; it lands
// in a two-entry queue, so the host can push the next item while the back end
// works. Loads and fetches with nothing pending are taken in the idle state;
// a fetch with a result holds the back end through its read (FRD) and compare
// (FCMP) states, then raises a one-cycle valid strobe from the compare.
// The receiver cannot stall: take pixel_out/last whenever valid is high.
// The last load of a frame kicks off the compute pass; per pixel it runs nine
// serial pixel-RAM reads, a squaring step, a sqrt start, one sqrt bit per
// cycle (the root is MAG_W = 11 + FRAC_BITS bits wide) plus a done strobe,
// and a write; busy stays high once the queue fills during that pass.
// Writing rows or cols aborts any frame and busy is high for one cycle
// after the write.
module sobel_edge_mean_threshold #(
  parameter int MAX_ROWS  = sem_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS  = sem_pkg::DEF_MAX_COLS,
  parameter int FRAC_BITS = sem_pkg::DEF_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          kind,
  input  logic [sem_pkg::PIX_W-1:0]     pixel_in,
  output logic                          valid,
  output logic [sem_pkg::PIX_W-1:0]     pixel_out,
  output logic                          last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [sem_pkg::DIM_IN_W-1:0]  cfg_data
);

  sem_pkg::item_t in_item, head_item;
  logic           q_full, head_valid, head_pop;
  logic           cfg_we;
  logic           cfg_settle;  // total = rows*cols is re-registered after a write

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign busy      = q_full || cfg_settle;

  assign in_item.kind  = kind;
  assign in_item.pixel = pixel_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_settle <= 1'b0;
    end else begin
      cfg_settle <= cfg_we;
    end
  end

  sem_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (start && !busy),
    .push_item  (in_item),
    .full       (q_full),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (head_pop)
  );

  sem_back #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_COLS  (MAX_COLS),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (head_valid),
    .item       (head_item),
    .item_pop   (head_pop),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_valid  (valid),
    .pixel_out  (pixel_out),
    .last       (last)
  );

endmodule

>>> sim/sobel_edge_mean_threshold_tb.sv
// Self-checking testbench for sobel_edge_mean_threshold: loads small frames,
// fetches the edge marks and compares them with an in-bench Sobel/mean model.
// Depends on sem_pkg and the RTL under rtl/core.
`timescale 1ns / 100ps

module sobel_edge_mean_threshold_tb;

  localparam int STORE_DEPTH = sem_pkg::DEF_MAX_ROWS * sem_pkg::DEF_MAX_COLS;
  localparam int WATCHDOG_LIMIT = 200000;

  typedef struct packed {
    logic [sem_pkg::PIX_W-1:0] pixel;
    logic                      last;
  } mark_t;

  logic                         clk;
  logic                         rst;
  logic                         start;
  logic                         busy;
  logic                         kind;
  logic [sem_pkg::PIX_W-1:0]    pixel_in;
  logic                         valid;
  logic [sem_pkg::PIX_W-1:0]    pixel_out;
  logic                         last;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic                         cfg_index;
  logic [sem_pkg::DIM_IN_W-1:0] cfg_data;

  sobel_edge_mean_threshold u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .pixel_in(pixel_in), .valid(valid), .pixel_out(pixel_out), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // ---------------------------------------------------------------------
  // Shadow state of the block
  // ---------------------------------------------------------------------
  int unsigned       img_rows, img_cols;
  byte unsigned      pix_mem [STORE_DEPTH];
  int unsigned       mag_mem [STORE_DEPTH];
  longint unsigned   mag_total;
  int unsigned       load_ptr, fetch_ptr;
  bit                marks_ready;
  bit                pass_pending;  // a compute pass may still be running
  mark_t             marks_expected[$];

  int  fail_count;
  int  idle_cycles;
  bit  no_gaps;      // burst mode: sender never idles

  // Register values: 0 reads as 1, anything above the maximum saturates.
  function automatic int unsigned clamp_dim(input logic [sem_pkg::DIM_IN_W-1:0] v,
                                            input int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic void clear_frame();
    mag_total = 0;
    load_ptr = 0;
    fetch_ptr = 0;
    marks_ready = 0;
  endfunction

  // Sobel X/Y with toroidal wrap, magnitude in Q.FRAC_BITS, plus running sum.
  function automatic void compute_magnitudes();
    int r, c, dr, dc, nr, nc, gx, gy, p;
    longint unsigned sq, mag;
    mag_total = 0;
    for (r = 0; r < img_rows; r++) begin
      for (c = 0; c < img_cols; c++) begin
        gx = 0;
        gy = 0;
        for (dr = -1; dr <= 1; dr++) begin
          nr = (r + img_rows + dr) % img_rows;
          for (dc = -1; dc <= 1; dc++) begin
            nc = (c + img_cols + dc) % img_cols;
            p = pix_mem[(nr * img_cols + nc) % STORE_DEPTH];
            gx += p * dc * (dr == 0 ? 2 : 1);
            gy += p * dr * (dc == 0 ? 2 : 1);
          end
        end
        sq = longint'(gx * gx) + longint'(gy * gy);
        mag = int_sqrt(sq << (2 * sem_pkg::DEF_FRAC_BITS));
        mag_mem[(r * img_cols + c) % STORE_DEPTH] = int'(mag);
        mag_total += mag;
      end
    end
  endfunction

  // Update the shadow state for one accepted item; queue a mark if one is due.
  function automatic void predict_item(input logic k, input logic [sem_pkg::PIX_W-1:0] pix);
    int unsigned total;
    mark_t m;
    total = img_rows * img_cols;
    if (k == sem_pkg::KIND_LOAD) begin
      if (marks_ready) begin
        // load while marks are pending starts a new frame
        marks_ready = 0;
        fetch_ptr = 0;
        load_ptr = 0;
      end
      pix_mem[load_ptr % STORE_DEPTH] = pix;
      load_ptr++;
      if (load_ptr >= total) begin
        compute_magnitudes();
        pass_pending = 1;
        load_ptr = 0;
        fetch_ptr = 0;
        marks_ready = 1;
      end
    end else if (marks_ready) begin
      m.pixel = (longint'(mag_mem[fetch_ptr % STORE_DEPTH]) * total >= mag_total)
                ? sem_pkg::EDGE_VALUE : sem_pkg::BACKGROUND_VALUE;
      m.last = (fetch_ptr + 1 >= total);
      marks_expected.push_back(m);
      if (m.last) begin
        fetch_ptr = 0;
        marks_ready = 0;
      end else begin
        fetch_ptr++;
      end
    end
  endfunction

  // ---------------------------------------------------------------------
  // Result checker: the receiver cannot stall, take every strobe
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    mark_t m;
    if (!rst && valid) begin
      if (marks_expected.size() == 0) begin
        $error("unexpected mark: pixel_out=%0d last=%0d", pixel_out, last);
        fail_count++;
      end else begin
        m = marks_expected.pop_front();
        if (pixel_out !== m.pixel) begin
          $error("pixel_out: expected %0d, got %0d", m.pixel, pixel_out);
          fail_count++;
        end
        if (last !== m.last) begin
          $error("last: expected %0d, got %0d", m.last, last);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: cycles with nothing accepted on any side.
  always @(posedge clk) begin
    if (rst || valid || (start && !busy) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------
  // Sends one item; start stays high afterwards so back-to-back items need
  // no dip. Random idle gaps come before about one item in ten, unless in burst mode.
  task automatic send_item(input logic k, input logic [sem_pkg::PIX_W-1:0] pix);
    @(negedge clk);
    if (!no_gaps && $urandom_range(99) < 10) begin
      start = 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk);
    end
    start = 1'b1;
    kind = k;
    pixel_in = pix;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    predict_item(k, pix);
  endtask

  task automatic stop_items();
    @(negedge clk);
    start = 1'b0;
  endtask

  // Wait for every pending mark plus enough cycles for a compute pass that
  // might still be running (no mark marks its end).
  task automatic drain();
    stop_items();
    while (marks_expected.size() != 0) @(posedge clk);
    if (pass_pending)
      repeat (img_rows * img_cols * 40 + 40) @(posedge clk);
    else
      repeat (4) @(posedge clk);
    pass_pending = 0;
  endtask

  task automatic write_reg(input logic idx, input logic [sem_pkg::DIM_IN_W-1:0] val);
    drain();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    if (idx == sem_pkg::CFG_ROWS) img_rows = clamp_dim(val, sem_pkg::DEF_MAX_ROWS);
    else img_cols = clamp_dim(val, sem_pkg::DEF_MAX_COLS);
    clear_frame();
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_size(input logic [sem_pkg::DIM_IN_W-1:0] r,
                          input logic [sem_pkg::DIM_IN_W-1:0] c);
    write_reg(sem_pkg::CFG_ROWS, r);
    write_reg(sem_pkg::CFG_COLS, c);
  endtask

  // Loads a whole frame; style picks flat, two-level or random content.
  task automatic load_frame(input int style);
    int i;
    logic [sem_pkg::PIX_W-1:0] flat;
    flat = sem_pkg::PIX_W'($urandom_range(255));
    for (i = 0; i < img_rows * img_cols; i++) begin
      case (style)
        0: send_item(sem_pkg::KIND_LOAD, flat);
        1: send_item(sem_pkg::KIND_LOAD, $urandom_range(1) ? 8'd255 : 8'd0);
        default: send_item(sem_pkg::KIND_LOAD, sem_pkg::PIX_W'($urandom_range(255)));
      endcase
    end
  endtask

  task automatic fetch_marks(input int n);
    repeat (n) send_item(sem_pkg::KIND_FETCH, sem_pkg::PIX_W'($urandom_range(255)));
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  // Zero-valued registers count as 1: single-pixel frame, fetch past end.
  task automatic test_single_pixel();
    set_size(9'd0, 9'd0);
    fetch_marks(1);                 // nothing ready yet
    send_item(sem_pkg::KIND_LOAD, 8'd255);
    fetch_marks(2);                 // second fetch gives nothing
    send_item(sem_pkg::KIND_LOAD, 8'd0);
    fetch_marks(1);
  endtask

  // Register maxima and saturation: one tall column, one wide row.
  task automatic test_extreme_sizes();
    set_size(9'd511, 9'd1);
    load_frame(2);
    fetch_marks(img_rows * img_cols);
    set_size(9'd1, 9'd256);
    load_frame(1);
    fetch_marks(img_rows * img_cols);
  endtask

  // Register write aborts a half-loaded frame; load mid-fetch restarts.
  task automatic test_abort_and_restart();
    set_size(9'd3, 9'd4);
    load_frame(0);                  // flat frame: every pixel is an edge
    fetch_marks(12);
    send_item(sem_pkg::KIND_LOAD, 8'd17);
    send_item(sem_pkg::KIND_LOAD, 8'd200);
    write_reg(sem_pkg::CFG_COLS, 9'd3);      // drops the partial frame
    load_frame(2);
    fetch_marks(4);
    load_frame(2);                  // drops the remaining marks
    fetch_marks(9);
    fetch_marks(1);
  endtask

  task automatic test_random_frames();
    int sent, n, i;
    sent = 0;
    while (sent < 760) begin
      no_gaps = (sent > 200 && sent < 500);
      if ($urandom_range(99) < 60 || sent == 0) begin
        if ($urandom_range(19) == 0)
          set_size(sem_pkg::DIM_IN_W'($urandom_range(16, 9)),
                   sem_pkg::DIM_IN_W'($urandom_range(16, 1)));
        else
          set_size(sem_pkg::DIM_IN_W'($urandom_range(8, 1)),
                   sem_pkg::DIM_IN_W'($urandom_range(8, 1)));
      end
      load_frame($urandom_range(9) == 0 ? 0 : ($urandom_range(4) == 0 ? 1 : 2));
      sent += img_rows * img_cols;
      case ($urandom_range(9))
        0: n = int'($urandom_range(img_rows * img_cols));          // partial fetch
        1: n = int'(img_rows * img_cols + $urandom_range(3, 1));   // overrun
        default: n = int'(img_rows * img_cols);
      endcase
      fetch_marks(n);
      sent += n;
      if ($urandom_range(9) == 0) begin
        // noise: three stray items, each a fetch or a load at random
        for (i = 0; i < 3; i++)
          send_item(1'($urandom_range(1)), sem_pkg::PIX_W'($urandom_range(255)));
        sent += 3;
      end
    end
    no_gaps = 0;
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    kind = sem_pkg::KIND_LOAD;
    pixel_in = '0;
    cfg_valid = 1'b0;
    cfg_index = sem_pkg::CFG_ROWS;
    cfg_data = '0;
    fail_count = 0;
    no_gaps = 0;
    pass_pending = 0;
    img_rows = sem_pkg::DEF_MAX_ROWS;
    img_cols = sem_pkg::DEF_MAX_COLS;
    clear_frame();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_single_pixel();
    test_extreme_sizes();
    test_abort_and_restart();
    test_random_frames();

    stop_items();
    while (marks_expected.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/sem_pkg.sv
rtl/core/sem_ram.sv
rtl/core/sem_isqrt.sv
rtl/core/sem_front.sv
rtl/core/sem_back.sv
rtl/core/sobel_edge_mean_threshold.sv
sim/sobel_edge_mean_threshold_tb.sv
